// File: rtl/brse_pkg.sv
// Shared types, codes and constants for the bitmap row span extractor.
package brse_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int unsigned DEF_MAX_ROW_BYTES = 32;
    localparam int unsigned DEF_MAX_ROWS      = 256;

    // Width used for counter and limit comparisons (covers every parameter value)
    localparam int unsigned CMP_W = 16;

    // Field widths fixed by the command format
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned PLANE_W = 2;
    localparam int unsigned RB_W    = 6;
    localparam int unsigned RC_W    = 9;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned ADDR_W  = 2;
    localparam int unsigned PIX_N   = 8;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPAN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_ROW_BYTES = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_PLANE     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [RB_W-1:0]    RST_ROW_BYTES = 6'd32;
    localparam logic [RC_W-1:0]    RST_ROW_COUNT = 9'd256;
    localparam logic [PLANE_W-1:0] RST_PLANE     = 2'd0;

    // Pixel byte codes
    localparam logic [BYTE_W-1:0] BYTE_FULL  = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_EMPTY = 8'h00;

    // Pending-command vector: emitted from the lowest set bit upwards
    localparam int unsigned PEND_W      = 11;
    localparam int unsigned PEND_CLEAR  = 0;
    localparam int unsigned PEND_SPAN1  = 1;
    localparam int unsigned PEND_PIX0   = 2;
    localparam int unsigned PEND_SPAN2  = 10;

    // One accepted request, decoded into the commands it causes
    typedef struct packed {
        logic [PEND_W-1:0]  pend;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] base;
        logic [COORD_W-1:0] s1_start;
        logic [COORD_W-1:0] s2_start;
        logic [PLANE_W-1:0] plane;
    } rec_t;

    // Emitter status seen by the top level
    typedef struct packed {
        logic busy;
        logic one_left;
    } stat_t;

endpackage

// File: rtl/bitmap_row_span_extractor.sv
// Top level of the bitmap row span extractor: ports, handshake and checks.
//
//   channel   direction  handshake            payload
//   s_axis    in         s_tvalid / s_tready  s_tdata pixel byte, s_tuser first of image
//   m_axis    out        m_tvalid / m_tready  m_tdata draw command, m_tlast end of request
//   config    in         cfg_we               cfg_addr register index, cfg_wdata value
//
// A request that causes at most one command is taken every cycle while m_tready is high;
// a request that causes N commands (N up to 8: a clear or closing span, seven pixels)
// holds the command register until its last command is taken. The output register passes
// one command a cycle; commands go from the command register into the output register.
// Reset is asynchronous and active low; it restores the configuration defaults and
// position row 0 byte 0. While m_tready is low the output register and any pending
// commands hold; one further request that causes commands may be taken into an empty
// command register, and requests that cause none are still taken.
module bitmap_row_span_extractor #(
    parameter int unsigned MAX_ROW_BYTES = brse_pkg::DEF_MAX_ROW_BYTES,
    parameter int unsigned MAX_ROWS      = brse_pkg::DEF_MAX_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [brse_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [brse_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] pixel_byte
    input  logic                        s_tuser,  // [0] first_of_image
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [1:0] cmd_kind, [9:2] row, [17:10] col_start, [25:18] col_end,
    // [27:26] plane, [31:28] zero
    output logic [31:0]                 m_tdata,
    output logic                        m_tlast
);

    brse_pkg::rec_t  rec;
    brse_pkg::stat_t stat;
    logic            accept;

    logic [brse_pkg::KIND_W-1:0]  cmd_kind;
    logic [brse_pkg::COORD_W-1:0] row;
    logic [brse_pkg::COORD_W-1:0] col_start;
    logic [brse_pkg::COORD_W-1:0] col_end;
    logic [brse_pkg::PLANE_W-1:0] plane;

    // Take a request when the command register is empty or frees this cycle
    assign s_tready = !stat.busy || (stat.one_left && (!m_tvalid || m_tready));
    assign accept   = s_tvalid && s_tready;

    brse_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .accept         (accept),
        .pixel_byte     (s_tdata),
        .first_of_image (s_tuser),
        .rec            (rec)
    );

    brse_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .rec_in    (rec),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd_kind  (cmd_kind),
        .row       (row),
        .col_start (col_start),
        .col_end   (col_end),
        .plane     (plane),
        .last      (m_tlast)
    );

    // Pack the command
    assign m_tdata = {4'b0000, plane, col_end, col_start, row, cmd_kind};

`ifndef SYNTHESIS
    // A new image always leaves a clear pending
    a_first_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser |=> stat.busy)
        else $error("first of image left no pending command");

    // Commands of one request follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside the commands of one request");

    // A clear carries zero coordinates
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (cmd_kind == brse_pkg::KIND_CLEAR) |->
            (row == '0) && (col_start == '0) && (col_end == '0))
        else $error("clear command with non-zero coordinates");
`endif

endmodule

// File: rtl/brse_front.sv
// Row and run tracking: configuration registers, position state and command decode.
module brse_front #(
    parameter int unsigned MAX_ROW_BYTES = brse_pkg::DEF_MAX_ROW_BYTES,
    parameter int unsigned MAX_ROWS      = brse_pkg::DEF_MAX_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [brse_pkg::ADDR_W-1:0]       cfg_addr,
    input  logic [brse_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              accept,
    input  logic [brse_pkg::BYTE_W-1:0]       pixel_byte,
    input  logic                              first_of_image,
    output brse_pkg::rec_t                    rec
);

    localparam int unsigned BI_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int unsigned RI_W = $clog2(MAX_ROWS + 1);
    localparam int unsigned CW   = brse_pkg::CMP_W;

    logic [brse_pkg::RB_W-1:0]    row_bytes_reg;
    logic [brse_pkg::RC_W-1:0]    row_count_reg;
    logic [brse_pkg::PLANE_W-1:0] plane_reg;

    logic [RI_W-1:0] row_index_reg, row_index_next;
    logic [BI_W-1:0] byte_index_reg, byte_index_next;
    logic            run_open_reg, run_open_next;
    logic [BI_W-1:0] run_first_reg, run_first_next;

    logic [RI_W-1:0] ri;
    logic [BI_W-1:0] bi;
    logic            ro;
    logic [BI_W-1:0] rf;
    logic [BI_W-1:0] rf_new;
    logic [CW-1:0]   rb0;
    logic [CW-1:0]   rb_eff;
    logic [CW-1:0]   rows_eff;
    logic            active;
    logic            row_end;
    logic            is_full;

    // Take configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= brse_pkg::RST_ROW_BYTES;
            row_count_reg <= brse_pkg::RST_ROW_COUNT;
            plane_reg     <= brse_pkg::RST_PLANE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                brse_pkg::CFG_ROW_BYTES: row_bytes_reg <= cfg_wdata[brse_pkg::RB_W-1:0];
                brse_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_wdata[brse_pkg::RC_W-1:0];
                brse_pkg::CFG_PLANE:     plane_reg     <= cfg_wdata[brse_pkg::PLANE_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Clamp the row geometry to the supported range
    always_comb
    begin
        rb0      = (row_bytes_reg == '0) ? CW'(1) : CW'(row_bytes_reg);
        rb_eff   = (rb0 > CW'(MAX_ROW_BYTES)) ? CW'(MAX_ROW_BYTES) : rb0;
        rows_eff = (CW'(row_count_reg) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(row_count_reg);
    end

    // Decode the request and work out the next position and run state
    always_comb
    begin
        // A new image restarts at row 0 byte 0 and drops any open run
        ri = first_of_image ? '0 : row_index_reg;
        bi = first_of_image ? '0 : byte_index_reg;
        ro = first_of_image ? 1'b0 : run_open_reg;
        rf = first_of_image ? '0 : run_first_reg;

        active  = CW'(ri) < rows_eff;
        row_end = (CW'(bi) + CW'(1)) >= rb_eff;
        is_full = pixel_byte == brse_pkg::BYTE_FULL;
        rf_new  = (is_full && !ro) ? bi : rf;

        rec.pend = '0;
        rec.pend[brse_pkg::PEND_CLEAR] = first_of_image;
        rec.pend[brse_pkg::PEND_SPAN1] = active && !is_full && ro;
        rec.pend[brse_pkg::PEND_PIX0 +: brse_pkg::PIX_N] =
            (active && !is_full) ? pixel_byte : brse_pkg::BYTE_EMPTY;
        rec.pend[brse_pkg::PEND_SPAN2] = active && row_end && is_full;

        rec.row      = brse_pkg::COORD_W'(ri);
        rec.base     = brse_pkg::COORD_W'({bi, 3'b000});
        rec.s1_start = brse_pkg::COORD_W'({rf, 3'b000});
        rec.s2_start = brse_pkg::COORD_W'({rf_new, 3'b000});
        rec.plane    = plane_reg;

        // Hold position past the last row
        row_index_next  = ri;
        byte_index_next = bi;
        run_open_next   = ro;
        run_first_next  = rf;
        if (active)
        begin
            run_open_next  = is_full && !row_end;
            run_first_next = rf_new;
            if (row_end)
            begin
                byte_index_next = '0;
                row_index_next  = ri + RI_W'(1);
            end
            else
            begin
                byte_index_next = bi + BI_W'(1);
            end
        end
    end

    // Advance the position on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg  <= '0;
            byte_index_reg <= '0;
            run_open_reg   <= 1'b0;
            run_first_reg  <= '0;
        end
        else if (accept)
        begin
            row_index_reg  <= row_index_next;
            byte_index_reg <= byte_index_next;
            run_open_reg   <= run_open_next;
            run_first_reg  <= run_first_next;
        end
    end

endmodule

// File: rtl/brse_emit.sv
// Command register and output register: serialise the commands of one request.
module brse_emit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  brse_pkg::rec_t                    rec_in,
    output brse_pkg::stat_t                   stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [brse_pkg::KIND_W-1:0]       cmd_kind,
    output logic [brse_pkg::COORD_W-1:0]      row,
    output logic [brse_pkg::COORD_W-1:0]      col_start,
    output logic [brse_pkg::COORD_W-1:0]      col_end,
    output logic [brse_pkg::PLANE_W-1:0]      plane,
    output logic                              last
);

    brse_pkg::rec_t rec_reg;
    logic [brse_pkg::PEND_W-1:0] pend_reg, pend_next;

    logic                             out_valid_reg, out_valid_next;
    logic [brse_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [brse_pkg::COORD_W-1:0]     row_reg;
    logic [brse_pkg::COORD_W-1:0]     c0_reg, c0_next;
    logic [brse_pkg::COORD_W-1:0]     c1_reg, c1_next;
    logic [brse_pkg::PLANE_W-1:0]     plane_reg;
    logic                             last_reg, last_next;

    logic                         adv;
    logic                         take;
    logic [brse_pkg::PEND_W-1:0]  sel;
    logic [2:0]                   pix_idx;
    logic [brse_pkg::COORD_W-1:0] pix_col;

    // Pick the lowest pending command and build it
    always_comb
    begin
        adv     = !out_valid_reg || out_ready;
        take    = adv && (pend_reg != '0);
        sel     = pend_reg & (~pend_reg + brse_pkg::PEND_W'(1));
        pix_idx = '0;
        for (int i = 0; i < brse_pkg::PIX_N; i++)
        begin
            if (sel[brse_pkg::PEND_PIX0 + i])
            begin
                pix_idx = pix_idx | 3'(i);
            end
        end
        pix_col = rec_reg.base + brse_pkg::COORD_W'(pix_idx);

        if (sel[brse_pkg::PEND_CLEAR])
        begin
            kind_next = brse_pkg::KIND_CLEAR;
            c0_next   = '0;
            c1_next   = '0;
        end
        else if (sel[brse_pkg::PEND_SPAN1])
        begin
            kind_next = brse_pkg::KIND_SPAN;
            c0_next   = rec_reg.s1_start;
            c1_next   = rec_reg.base - brse_pkg::COORD_W'(1);
        end
        else if (sel[brse_pkg::PEND_SPAN2])
        begin
            kind_next = brse_pkg::KIND_SPAN;
            c0_next   = rec_reg.s2_start;
            c1_next   = rec_reg.base + brse_pkg::COORD_W'(7);
        end
        else
        begin
            kind_next = brse_pkg::KIND_PIXEL;
            c0_next   = pix_col;
            c1_next   = pix_col;
        end

        last_next      = (pend_reg & ~sel) == '0;
        out_valid_next = adv ? (pend_reg != '0) : out_valid_reg;

        // Drop the taken command; a new request overwrites an emptied record
        pend_next = take ? (pend_reg & ~sel) : pend_reg;
        if (load)
        begin
            pend_next = rec_in.pend;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload of the record and the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_in;
        end
        if (take)
        begin
            kind_reg  <= kind_next;
            row_reg   <= sel[brse_pkg::PEND_CLEAR] ? '0 : rec_reg.row;
            c0_reg    <= c0_next;
            c1_reg    <= c1_next;
            plane_reg <= rec_reg.plane;
            last_reg  <= last_next;
        end
    end

    assign stat.busy     = pend_reg != '0;
    assign stat.one_left = $onehot(pend_reg);

    assign out_valid = out_valid_reg;
    assign cmd_kind  = kind_reg;
    assign row       = row_reg;
    assign col_start = c0_reg;
    assign col_end   = c1_reg;
    assign plane     = plane_reg;
    assign last      = last_reg;

endmodule
